// File: hw/rtl/fmas_pkg.sv
// Shared constants, types, microcode program and sine helper for the FM/AM synthesizer.
package fmas_pkg;

   localparam int VOICES_DEF       = 5;
   localparam int SINE_ENTRIES_DEF = 1024;
   localparam int PHASE_BITS_DEF   = 32;

   localparam int SAMPLE_RATE = 44100;
   localparam int STEP_DIV    = 16 * SAMPLE_RATE;
   localparam int QSHIFT      = 18;
   localparam int REM_W       = 22;
   localparam int MUL_A_W     = 21;
   localparam int FREQ_W      = 18;
   localparam int FMAG_W      = 17;
   localparam int AMG_W       = 30;
   localparam int MIX_SHIFT   = 30;
   localparam int SAMPLE_W    = 16;

   localparam logic [14:0] MIX_GAIN_RESET = 15'd6554;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_SET_VOICE = 2'd1,
      OP_SET_MOD   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_STEP,
      MUL_FIX,
      MUL_IDX,
      MUL_AMG,
      MUL_DEV,
      MUL_MIX
   } mul_sel_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LD_F,
      DP_QEST,
      DP_FIX,
      DP_ADV,
      DP_RD,
      DP_SM,
      DP_AMG,
      DP_DEV,
      DP_ACC,
      DP_NEXT,
      DP_OUT
   } dp_op_type;

   typedef enum logic {
      TGT_MOD,
      TGT_VOICE
   } tgt_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_OFF,
      JMP_MORE
   } jmp_type;

   localparam int PC_W = 5;
   localparam int UC_LEN = 21;
   localparam logic [PC_W-1:0] L_VOICE = 5'd10;
   localparam logic [PC_W-1:0] L_NEXT  = 5'd19;

   typedef struct packed {
      mul_sel_type     mul_sel;
      dp_op_type       dp_op;
      tgt_type         tgt;
      jmp_type         jmp;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   function automatic ctrl_word_type cw_make(input mul_sel_type m, input dp_op_type d,
                                             input tgt_type t, input jmp_type j,
                                             input logic [PC_W-1:0] a);
      ctrl_word_type w;
      w.mul_sel = m;
      w.dp_op   = d;
      w.tgt     = t;
      w.jmp     = j;
      w.target  = a;
      return w;
   endfunction

   function automatic ctrl_word_type ucode(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = cw_make(MUL_NONE, DP_NOP, TGT_MOD, JMP_NONE, '0);
      unique case (pc)
         5'd0:  w = cw_make(MUL_NONE, DP_LD_F, TGT_MOD,   JMP_NONE, '0);
         5'd1:  w = cw_make(MUL_STEP, DP_NOP,  TGT_MOD,   JMP_NONE, '0);
         5'd2:  w = cw_make(MUL_FIX,  DP_QEST, TGT_MOD,   JMP_NONE, '0);
         5'd3:  w = cw_make(MUL_NONE, DP_FIX,  TGT_MOD,   JMP_NONE, '0);
         5'd4:  w = cw_make(MUL_NONE, DP_ADV,  TGT_MOD,   JMP_NONE, '0);
         5'd5:  w = cw_make(MUL_IDX,  DP_NOP,  TGT_MOD,   JMP_NONE, '0);
         5'd6:  w = cw_make(MUL_NONE, DP_RD,   TGT_MOD,   JMP_NONE, '0);
         5'd7:  w = cw_make(MUL_AMG,  DP_SM,   TGT_MOD,   JMP_NONE, '0);
         5'd8:  w = cw_make(MUL_DEV,  DP_AMG,  TGT_MOD,   JMP_NONE, '0);
         5'd9:  w = cw_make(MUL_NONE, DP_DEV,  TGT_MOD,   JMP_NONE, '0);
         5'd10: w = cw_make(MUL_NONE, DP_LD_F, TGT_VOICE, JMP_OFF,  L_NEXT);
         5'd11: w = cw_make(MUL_STEP, DP_NOP,  TGT_VOICE, JMP_NONE, '0);
         5'd12: w = cw_make(MUL_FIX,  DP_QEST, TGT_VOICE, JMP_NONE, '0);
         5'd13: w = cw_make(MUL_NONE, DP_FIX,  TGT_VOICE, JMP_NONE, '0);
         5'd14: w = cw_make(MUL_NONE, DP_ADV,  TGT_VOICE, JMP_NONE, '0);
         5'd15: w = cw_make(MUL_IDX,  DP_NOP,  TGT_VOICE, JMP_NONE, '0);
         5'd16: w = cw_make(MUL_NONE, DP_RD,   TGT_VOICE, JMP_NONE, '0);
         5'd17: w = cw_make(MUL_MIX,  DP_NOP,  TGT_VOICE, JMP_NONE, '0);
         5'd18: w = cw_make(MUL_NONE, DP_ACC,  TGT_VOICE, JMP_NONE, '0);
         5'd19: w = cw_make(MUL_NONE, DP_NEXT, TGT_VOICE, JMP_MORE, L_VOICE);
         5'd20: w = cw_make(MUL_NONE, DP_OUT,  TGT_VOICE, JMP_NONE, '0);
         default: ;
      endcase
      return w;
   endfunction

   // quarter-wave polynomial in Q15, negated for the lower half-turn
   function automatic logic [SAMPLE_W-1:0] sine_entry(input longint unsigned x,
                                                      input logic neg);
      longint unsigned x2;
      longint unsigned x3;
      longint unsigned x5;
      longint unsigned acc;
      longint unsigned s;
      x2  = (x * x) >> 15;
      x3  = (x2 * x) >> 15;
      x5  = (x3 * x2) >> 15;
      acc = 64'd51472 * x + 64'd2611 * x5 - 64'd21167 * x3;
      s   = (acc + 64'd16384) >> 15;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return neg ? SAMPLE_W'(-s) : SAMPLE_W'(s);
   endfunction

endpackage

// File: hw/rtl/fmas_req_if.sv
// Request channel interface: synth command with valid/ready handshake.
interface fmas_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        op;
   logic [2:0]        voice_index;
   logic              voice_on;
   logic [15:0]       carrier_freq;
   logic signed [9:0] mod_freq;
   logic [15:0]       fm_depth;

   modport source (
      output valid, op, voice_index, voice_on, carrier_freq, mod_freq, fm_depth,
      input  ready
   );
   modport sink (
      input  valid, op, voice_index, voice_on, carrier_freq, mod_freq, fm_depth,
      output ready
   );
endinterface

// File: hw/rtl/fmas_rsp_if.sv
// Response channel interface: mixed audio sample with valid/ready handshake.
interface fmas_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;

   modport source (
      output valid, sample,
      input  ready
   );
   modport sink (
      input  valid, sample,
      output ready
   );
endinterface

// File: hw/rtl/fmas_sine_rom.sv
// Sine lookup memory with registered read, contents fixed at elaboration.
module fmas_sine_rom #(
   parameter int SINE_ENTRIES = fmas_pkg::SINE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              rd_en,
   input  logic [$clog2(SINE_ENTRIES)-1:0]   rd_addr,
   output logic signed [fmas_pkg::SAMPLE_W-1:0] rd_data
);

   logic [fmas_pkg::SAMPLE_W-1:0]        sine_table [SINE_ENTRIES];
   logic signed [fmas_pkg::SAMPLE_W-1:0] rd_data_ff;

   for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_entry
      localparam int Quarter = SINE_ENTRIES / 4;
      localparam int Quad    = g / Quarter;
      localparam int Rem     = g % Quarter;
      localparam int Pos     = (Quad % 2 == 1) ? Quarter - Rem : Rem;
      localparam longint unsigned Xq = (longint'(Pos) << 15) / Quarter;
      assign sine_table[g] = fmas_pkg::sine_entry(Xq, Quad >= 2);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= $signed(sine_table[rd_addr]);
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/fm_am_multivoice_synth.sv
// Five-voice FM/AM phase-accumulator synthesizer, microcoded top level.
//
//  channel | direction | handshake    | payload
//  req     | in        | valid/ready  | op, voice_index, voice_on, carrier_freq,
//          |           |              | mod_freq, fm_depth
//  rsp     | out       | valid/ready  | sample
//  csr     | in        | write enable | csr_wr_data (mix gain)
//
// Set requests complete in the cycle they are accepted.
// A tick holds req.ready low while the program runs: the program runs every
// phase step, sine index and mix term through one shared multiplier and the
// single read port of the sine memory.
// Reset clears all voice and modulator state and restores the mix gain to 6554.
// A tick that finishes while the previous sample is still unread holds at its last step.
module fm_am_multivoice_synth #(
   parameter int VOICES       = fmas_pkg::VOICES_DEF,
   parameter int SINE_ENTRIES = fmas_pkg::SINE_ENTRIES_DEF,
   parameter int PHASE_BITS   = fmas_pkg::PHASE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   fmas_req_if.sink    req,
   fmas_rsp_if.source  rsp,
   input  logic        csr_wr_en,
   input  logic [14:0] csr_wr_data
);

   localparam int VC_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int IDX_W   = $clog2(SINE_ENTRIES);
   localparam int AW      = fmas_pkg::MUL_A_W;
   localparam int BW      = (PHASE_BITS + 1 > 31) ? PHASE_BITS + 1 : 31;
   localparam int PROD_W  = AW + BW;
   localparam int QSH     = fmas_pkg::QSHIFT;
   localparam int KSHIFT  = PHASE_BITS + QSH;
   localparam int REM_W   = fmas_pkg::REM_W;
   localparam int FW      = fmas_pkg::FREQ_W;
   localparam int MW      = fmas_pkg::FMAG_W;
   localparam int GW      = fmas_pkg::AMG_W;
   localparam int SW      = fmas_pkg::SAMPLE_W;
   localparam int MSH     = fmas_pkg::MIX_SHIFT;
   localparam int ACC_W   = 47 + VC_W;
   localparam int PC_W    = fmas_pkg::PC_W;
   localparam logic [63:0] RECIP = (64'd1 << KSHIFT) / 64'(fmas_pkg::STEP_DIV);
   localparam logic [REM_W-1:0] DIV_C  = REM_W'(fmas_pkg::STEP_DIV);
   localparam logic [REM_W-1:0] DIV_C2 = REM_W'(2 * fmas_pkg::STEP_DIV);

   logic                     busy_ff, busy_in;
   logic [PC_W-1:0]          pc_ff, pc_in;
   logic [14:0]              gain_ff, gain_in;
   logic [PHASE_BITS-1:0]    mod_phase_ff, mod_phase_in;
   logic signed [9:0]        mod_step_ff, mod_step_in;
   logic [15:0]              depth_ff, depth_in;
   logic [PHASE_BITS-1:0]    vphase_ff [VOICES];
   logic [PHASE_BITS-1:0]    vphase_in [VOICES];
   logic [15:0]              vfreq_ff [VOICES];
   logic [15:0]              vfreq_in [VOICES];
   logic                     von_ff [VOICES];
   logic                     von_in [VOICES];
   logic [MW-1:0]            fmag_ff, fmag_in;
   logic                     fneg_ff, fneg_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [PHASE_BITS-1:0]    qest_ff, qest_in;
   logic signed [SW-1:0]     sm_ff, sm_in;
   logic [GW-1:0]            amg_ff, amg_in;
   logic signed [FW-1:0]     fdev_ff, fdev_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [VC_W-1:0]          vc_ff, vc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]     sample_ff, sample_in;

   fmas_pkg::ctrl_word_type  cw;
   logic                     req_fire;
   logic                     out_stall;
   logic                     jump_taken;
   logic                     last_voice;
   logic [PHASE_BITS-1:0]    phase_sel;
   logic [PHASE_BITS-1:0]    phase_step;
   logic signed [FW-1:0]     f_sel;
   logic signed [FW-1:0]     f_abs;
   logic [REM_W-1:0]         rem;
   logic signed [AW-1:0]     mul_a;
   logic signed [BW-1:0]     mul_b;
   logic [14:0]              am;
   logic                     rom_en;
   logic [IDX_W-1:0]         rom_addr;
   logic signed [SW-1:0]     rom_q;
   logic                     sat_fits;
   logic signed [SW-1:0]     sat_val;

   fmas_sine_rom #(
      .SINE_ENTRIES (SINE_ENTRIES)
   ) u_sine_rom (
      .clock   (clock),
      .rd_en   (rom_en),
      .rd_addr (rom_addr),
      .rd_data (rom_q)
   );

   assign cw         = fmas_pkg::ucode(pc_ff);
   assign req.ready  = !busy_ff;
   assign req_fire   = req.valid && req.ready;
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.sample = sample_ff;

   assign out_stall  = busy_ff && (cw.dp_op == fmas_pkg::DP_OUT) && rsp_valid_ff && !rsp.ready;
   assign last_voice = (vc_ff == VC_W'(VOICES - 1));
   assign phase_sel  = (cw.tgt == fmas_pkg::TGT_MOD) ? mod_phase_ff : vphase_ff[vc_ff];
   assign phase_step = fneg_ff ? (PHASE_BITS'(0) - qest_ff) : qest_ff;
   assign rem        = REM_W'(0) - prod_ff[REM_W-1:0];
   assign am         = {~rom_q[SW-1], rom_q[SW-2:1]};
   assign rom_en     = busy_ff && (cw.dp_op == fmas_pkg::DP_RD);
   assign rom_addr   = prod_ff[PHASE_BITS +: IDX_W];

   always_comb begin
      if (cw.tgt == fmas_pkg::TGT_MOD) begin
         f_sel = {{(FW-10){mod_step_ff[9]}}, mod_step_ff};
      end else begin
         f_sel = $signed({2'b00, vfreq_ff[vc_ff]}) + fdev_ff;
      end
      f_abs = f_sel[FW-1] ? -f_sel : f_sel;
   end

   always_comb begin
      unique case (cw.jmp)
         fmas_pkg::JMP_OFF:  jump_taken = !von_ff[vc_ff];
         fmas_pkg::JMP_MORE: jump_taken = !last_voice;
         default:            jump_taken = 1'b0;
      endcase
   end

   always_comb begin
      sat_fits = (acc_ff[ACC_W-1:MSH+SW-1] == {(ACC_W-MSH-SW+1){acc_ff[MSH+SW-1]}});
      if (sat_fits) begin
         sat_val = acc_ff[MSH +: SW];
      end else if (acc_ff[ACC_W-1]) begin
         sat_val = fmas_pkg::SAMPLE_MIN;
      end else begin
         sat_val = fmas_pkg::SAMPLE_MAX;
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cw.mul_sel)
         fmas_pkg::MUL_STEP: begin
            mul_a = $signed({{(AW-MW){1'b0}}, fmag_ff});
            mul_b = $signed(BW'(RECIP));
         end
         fmas_pkg::MUL_FIX: begin
            mul_a = AW'(fmas_pkg::STEP_DIV);
            mul_b = $signed({{(BW-PHASE_BITS){1'b0}}, prod_ff[QSH +: PHASE_BITS]});
         end
         fmas_pkg::MUL_IDX: begin
            mul_a = AW'(SINE_ENTRIES);
            mul_b = $signed({{(BW-PHASE_BITS){1'b0}}, phase_sel});
         end
         fmas_pkg::MUL_AMG: begin
            mul_a = $signed({{(AW-15){1'b0}}, am});
            mul_b = $signed({{(BW-15){1'b0}}, gain_ff});
         end
         fmas_pkg::MUL_DEV: begin
            mul_a = {{(AW-SW){sm_ff[SW-1]}}, sm_ff};
            mul_b = $signed({{(BW-16){1'b0}}, depth_ff});
         end
         fmas_pkg::MUL_MIX: begin
            mul_a = {{(AW-SW){rom_q[SW-1]}}, rom_q};
            mul_b = $signed({{(BW-GW){1'b0}}, amg_ff});
         end
         default: ;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      gain_in      = gain_ff;
      mod_phase_in = mod_phase_ff;
      mod_step_in  = mod_step_ff;
      depth_in     = depth_ff;
      vphase_in    = vphase_ff;
      vfreq_in     = vfreq_ff;
      von_in       = von_ff;
      fmag_in      = fmag_ff;
      fneg_in      = fneg_ff;
      prod_in      = prod_ff;
      qest_in      = qest_ff;
      sm_in        = sm_ff;
      amg_in       = amg_ff;
      fdev_in      = fdev_ff;
      acc_in       = acc_ff;
      vc_in        = vc_ff;
      rsp_valid_in = rsp_valid_ff;
      sample_in    = sample_ff;

      if (csr_wr_en) begin
         gain_in = csr_wr_data;
      end
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cw.mul_sel != fmas_pkg::MUL_NONE) begin
         prod_in = PROD_W'(mul_a * mul_b);
      end

      if (!busy_ff) begin
         if (req_fire) begin
            case (req.op)
               fmas_pkg::OP_TICK: begin
                  busy_in = 1'b1;
                  pc_in   = '0;
               end
               fmas_pkg::OP_SET_VOICE: begin
                  if (int'(req.voice_index) < VOICES) begin
                     von_in[VC_W'(req.voice_index)]   = req.voice_on;
                     vfreq_in[VC_W'(req.voice_index)] = req.carrier_freq;
                  end
               end
               fmas_pkg::OP_SET_MOD: begin
                  mod_step_in = req.mod_freq;
                  depth_in    = req.fm_depth;
               end
               default: ;
            endcase
         end
      end else if (!out_stall) begin
         pc_in = jump_taken ? cw.target : pc_ff + 1'b1;
         unique case (cw.dp_op)
            fmas_pkg::DP_LD_F: begin
               fneg_in = f_sel[FW-1];
               fmag_in = f_abs[MW-1:0];
            end
            fmas_pkg::DP_QEST: qest_in = prod_ff[QSH +: PHASE_BITS];
            fmas_pkg::DP_FIX: begin
               if (rem >= DIV_C) begin
                  qest_in = qest_ff + 1'b1;
               end
            end
            fmas_pkg::DP_ADV: begin
               if (cw.tgt == fmas_pkg::TGT_MOD) begin
                  mod_phase_in = mod_phase_ff + phase_step;
               end else begin
                  vphase_in[vc_ff] = vphase_ff[vc_ff] + phase_step;
               end
            end
            fmas_pkg::DP_SM:  sm_in  = rom_q;
            fmas_pkg::DP_AMG: amg_in = prod_ff[GW-1:0];
            fmas_pkg::DP_DEV: begin
               fdev_in = prod_ff[15 +: FW];
               acc_in  = '0;
               vc_in   = '0;
            end
            fmas_pkg::DP_ACC: acc_in = acc_ff + $signed(prod_ff[ACC_W-1:0]);
            fmas_pkg::DP_NEXT: begin
               if (!last_voice) begin
                  vc_in = vc_ff + 1'b1;
               end
            end
            fmas_pkg::DP_OUT: begin
               busy_in      = 1'b0;
               pc_in        = '0;
               rsp_valid_in = 1'b1;
               sample_in    = sat_val;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         gain_ff      <= fmas_pkg::MIX_GAIN_RESET;
         mod_phase_ff <= '0;
         mod_step_ff  <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int v = 0; v < VOICES; v++) begin
            vphase_ff[v] <= '0;
            vfreq_ff[v]  <= '0;
            von_ff[v]    <= 1'b0;
         end
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         gain_ff      <= gain_in;
         mod_phase_ff <= mod_phase_in;
         mod_step_ff  <= mod_step_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
         vphase_ff    <= vphase_in;
         vfreq_ff     <= vfreq_in;
         von_ff       <= von_in;
      end
   end

   always_ff @(posedge clock) begin
      fmag_ff   <= fmag_in;
      fneg_ff   <= fneg_in;
      prod_ff   <= prod_in;
      qest_ff   <= qest_in;
      sm_ff     <= sm_in;
      amg_ff    <= amg_in;
      fdev_ff   <= fdev_in;
      acc_ff    <= acc_in;
      vc_ff     <= vc_in;
      sample_ff <= sample_in;
   end

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (int'(pc_ff) < fmas_pkg::UC_LEN))
      else $error("program counter past end of microcode");

   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.op == fmas_pkg::OP_TICK) |=> (busy_ff && pc_ff == '0))
      else $error("accepted tick did not start the program");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cw.dp_op == fmas_pkg::DP_FIX) |-> (rem < DIV_C2))
      else $error("phase step quotient estimate off by more than one");

   a_out_emits: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cw.dp_op == fmas_pkg::DP_OUT && !out_stall) |=> (rsp.valid && !busy_ff))
      else $error("final step did not present a sample");

   a_voice_in_range: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cw.tgt == fmas_pkg::TGT_VOICE) |-> (int'(vc_ff) < VOICES))
      else $error("voice counter out of range");

endmodule
